// ----- rtl/rxwd_pkg.sv -----
package rxwd_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BLOCK_WORDS = 128;
    localparam int unsigned WIB_W       = $clog2(BLOCK_WORDS);
    localparam logic [WORD_W-1:0] BLOCK_BYTES = WORD_W'(BLOCK_WORDS * 4);
    localparam logic [WIB_W-1:0]  LAST_WIB    = WIB_W'(BLOCK_WORDS - 1);

    localparam logic [WORD_W-1:0] SEED_MASK   = 32'h8B12_BAB6;
    localparam logic [WORD_W-1:0] OFFSET_STEP = 32'h561A_9C1A;

    localparam int unsigned ROT_POS   = 7;
    localparam int unsigned ROT_OFF   = 2;
    localparam int unsigned ROT_KEY   = 10;
    localparam int unsigned ROT_CHAIN = 15;

    // Key and offset material for the block that starts at the current position.
    typedef struct packed {
        logic [WORD_W-1:0] mix;
        logic [WORD_W-1:0] off;
    } t_blk_init;

    // Per-word position events from the keystream core.
    typedef struct packed {
        logic step;
        logic sof;
        logic eob;
    } t_pos_ctl;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                                input int unsigned n);
        logic [2*WORD_W-1:0] dbl;
        dbl  = {x, x};
        rotr = dbl[n +: WORD_W];
    endfunction

    function automatic logic [WORD_W-1:0] blk_mix(input logic [WORD_W-1:0] p);
        blk_mix = p + (p >> 16) + (p >> 8) + (p >> 24);
    endfunction

endpackage

// ----- rtl/rxwd_blkinit.sv -----
module rxwd_blkinit
    import rxwd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pos_ctl  i_ctl,
    output t_blk_init o_init
);

    logic [WORD_W-1:0] r_block_position;
    logic [WORD_W-1:0] r_nxt_pos;
    logic [WORD_W-1:0] r_nxt_mix;
    logic [WORD_W-1:0] r_nxt_off1;
    logic [WORD_W-1:0] r_nxt_off;
    t_blk_init         r_cur;

    // The next block's material settles through r_nxt_pos, r_nxt_off1 and r_nxt_off after
    // the position moves; a block is at least BLOCK_WORDS words long, so it is ready in time.
    always_ff @(posedge i_clk) begin
        r_nxt_pos  <= r_block_position + BLOCK_BYTES;
        r_nxt_mix  <= blk_mix(r_nxt_pos);
        r_nxt_off1 <= r_nxt_pos + rotr(r_nxt_pos, ROT_POS);
        r_nxt_off  <= r_nxt_off1 + rotr(r_nxt_off1, ROT_OFF);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_position <= '0;
            r_cur            <= '0;
        end else if (i_ctl.step) begin
            if (i_ctl.sof) begin
                r_block_position <= '0;
                r_cur            <= '0;
            end else if (i_ctl.eob) begin
                r_block_position <= r_nxt_pos;
                r_cur.mix        <= r_nxt_mix;
                r_cur.off        <= r_nxt_off;
            end
        end
    end

    assign o_init = r_cur;

endmodule

// ----- rtl/rxwd_core.sv -----
module rxwd_core
    import rxwd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [WORD_W-1:0] i_cipher,
    input  logic              i_sof,
    input  t_blk_init         i_init,
    output logic [WORD_W-1:0] o_plain,
    output logic              o_eob,
    output t_pos_ctl          o_ctl
);

    logic [WORD_W-1:0] r_seed;
    logic [WIB_W-1:0]  r_wib;
    logic [WORD_W-1:0] r_key;
    logic [WORD_W-1:0] r_off;
    logic [WORD_W-1:0] r_chain;

    logic              w_start;
    logic [WORD_W-1:0] n_seed;
    logic [WIB_W-1:0]  w_wib;
    logic [WORD_W-1:0] w_key;
    logic [WORD_W-1:0] w_off;
    logic [WORD_W-1:0] w_chain;

    always_comb begin
        w_start = i_sof || (r_wib == '0);
        n_seed  = i_sof ? (i_cipher ^ SEED_MASK) : r_seed;
        w_wib   = i_sof ? '0 : r_wib;
        // A new file starts at position zero, whose key mix and offset are zero.
        if (i_sof) begin
            w_key = n_seed;
            w_off = '0;
        end else if (w_start) begin
            w_key = n_seed ^ i_init.mix;
            w_off = i_init.off;
        end else begin
            w_key = r_key;
            w_off = r_off;
        end
        w_chain = w_start ? '0 : r_chain;
    end

    assign o_plain = i_cipher ^ w_chain ^ w_key ^ w_off;
    assign o_eob   = (w_wib == LAST_WIB);

    assign o_ctl.step = i_step;
    assign o_ctl.sof  = i_sof;
    assign o_ctl.eob  = o_eob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed  <= '0;
            r_wib   <= '0;
            r_key   <= '0;
            r_off   <= '0;
            r_chain <= '0;
        end else if (i_step) begin
            r_seed  <= n_seed;
            r_wib   <= w_wib + WIB_W'(1);
            r_key   <= rotr(w_key, ROT_KEY);
            r_off   <= w_off + OFFSET_STEP;
            r_chain <= rotr(i_cipher, ROT_CHAIN);
        end
    end

endmodule

// ----- rtl/rolling_xor_word_decryptor.sv -----
// Each accepted input word passes through the input register and the result register.
// Throughput: one word per cycle while the output is taken; when the output stalls,
// the result register holds its word and the input register takes one only while empty;
// s_axis_tready drops with it full, since it follows m_axis_tready in the same cycle.
// Reset (i_rst_n, synchronous, active low) clears the seed, position, key, offset and
// chain to zero and empties both pipeline registers.
module rolling_xor_word_decryptor
    import rxwd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [WORD_W-1:0] s_axis_tdata,   // [31:0] cipher_word
    input  logic              s_axis_tuser,   // [0] start_of_file
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [WORD_W-1:0] m_axis_tdata,   // [31:0] plain_word
    output logic              m_axis_tlast
);

    logic              r_in_valid;
    logic [WORD_W-1:0] r_in_cipher;
    logic              r_in_sof;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_plain;
    logic              r_out_eob;

    logic              w_step;
    logic [WORD_W-1:0] w_plain;
    logic              w_eob;
    t_pos_ctl          w_ctl;
    t_blk_init         w_init;

    assign w_step        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_cipher <= s_axis_tdata;
            r_in_sof    <= s_axis_tuser;
        end
        if (w_step) begin
            r_out_plain <= w_plain;
            r_out_eob   <= w_eob;
        end
    end

    rxwd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_cipher (r_in_cipher),
        .i_sof    (r_in_sof),
        .i_init   (w_init),
        .o_plain  (w_plain),
        .o_eob    (w_eob),
        .o_ctl    (w_ctl)
    );

    rxwd_blkinit u_blkinit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_init  (w_init)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_plain;
    assign m_axis_tlast  = r_out_eob;

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input register empty but not ready");

    a_step_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> m_axis_tvalid)
        else $error("processed word did not reach the output register");

    a_sof_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_in_sof) |=> !m_axis_tlast)
        else $error("first word of a file marked as end of block");

endmodule

// ----- test/rxwd_checker.sv -----
module rxwd_checker
    import rxwd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [WORD_W-1:0] i_in_data,    // [31:0] cipher_word
    input  logic              i_in_sof,     // [0] start_of_file
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [WORD_W-1:0] i_out_data,   // [31:0] plain_word
    input  logic              i_out_last,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [WORD_W-1:0] plain;
        logic              eob;
    } t_plain_word;

    t_plain_word       plain_queue[$];
    logic [WORD_W-1:0] seed;
    logic [WORD_W-1:0] blk_pos;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] offset;
    logic [WORD_W-1:0] chain;
    logic [WIB_W-1:0]  word_idx;
    int                fails = 0;

    function automatic logic [WORD_W-1:0] ror(input logic [WORD_W-1:0] x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    // Advances the keystream by one cipher word and returns the plain word it yields.
    task automatic decrypt_next(input logic [WORD_W-1:0] c, input logic sof,
                                output t_plain_word r);
        logic [WORD_W-1:0] p;
        logic [WORD_W-1:0] off;
        if (sof) begin
            seed     = c ^ SEED_MASK;
            blk_pos  = '0;
            word_idx = '0;
        end
        if (word_idx == '0) begin
            p      = blk_pos;
            key    = seed ^ (p + (p >> 16) + (p >> 8) + (p >> 24));
            off    = p + ror(p, ROT_POS);
            off    = off + ror(off, ROT_OFF);
            offset = off;
            chain  = '0;
        end
        r.plain = c ^ chain ^ key ^ offset;
        r.eob   = (word_idx == WIB_W'(BLOCK_WORDS - 1));
        key     = ror(key, ROT_KEY);
        chain   = ror(c, ROT_CHAIN);
        offset  = offset + OFFSET_STEP;
        if (r.eob) begin
            word_idx = '0;
            blk_pos  = blk_pos + WORD_W'(BLOCK_WORDS * 4);
        end else begin
            word_idx = word_idx + WIB_W'(1);
        end
    endtask

    always @(posedge i_clk) begin
        t_plain_word exp_w;
        if (!i_rst_n) begin
            seed     = '0;
            blk_pos  = '0;
            key      = '0;
            offset   = '0;
            chain    = '0;
            word_idx = '0;
            plain_queue.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                decrypt_next(i_in_data, i_in_sof, exp_w);
                plain_queue.push_back(exp_w);
            end
            if (i_out_valid && i_out_ready) begin
                if (plain_queue.size() == 0) begin
                    $display("%0t: unexpected word: expected none, got %h last %b",
                             $time, i_out_data, i_out_last);
                    fails++;
                end else begin
                    exp_w = plain_queue.pop_front();
                    if (i_out_data !== exp_w.plain) begin
                        $display("%0t: plain word mismatch: expected %h, got %h",
                                 $time, exp_w.plain, i_out_data);
                        fails++;
                    end
                    if (i_out_last !== exp_w.eob) begin
                        $display("%0t: end of block mismatch: expected %b, got %b",
                                 $time, exp_w.eob, i_out_last);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= plain_queue.size();
    end

endmodule

// ----- test/tb.sv -----
module tb;
    import rxwd_pkg::*;

    localparam int LIMIT       = 200000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASE_WORDS = 135;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [WORD_W-1:0] s_axis_tdata  = '0;   // [31:0] cipher_word
    logic              s_axis_tuser  = 1'b0; // [0] start_of_file
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [WORD_W-1:0] m_axis_tdata;         // [31:0] plain_word
    logic              m_axis_tlast;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_reqs     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int phase_sent    = 0;
    int cycle_count   = 0;

    rolling_xor_word_decryptor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    rxwd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_sof     (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // A hold request from the sender stalls the output for a long stretch, so the
    // pipeline fills up and back-pressures the input.
    always @(posedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen     <= hold_reqs;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic [WORD_W-1:0] w, input logic sof);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= sof;
        do @(posedge i_clk); while (!s_axis_tready);
        phase_sent++;
    endtask

    // One file: a start word, random body, and a last word whose unused bytes are zero.
    task automatic send_file(input int len);
        logic [WORD_W-1:0] w;
        for (int i = 0; i < len; i++) begin
            w = rand_word();
            if (i == len - 1 && len > 1)
                w = w & (WORD_W'('1) >> (8 * $urandom_range(3)));
            send_word(w, i == 0);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int len;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Words before any file start run with the zero seed.
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h1234_5678, 1'b0);
        // A start word equal to the mask gives a zero seed.
        send_word(SEED_MASK, 1'b1);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h8000_0001, 1'b0);
        send_word(32'h0000_0000, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h5555_5555, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'hAAAA_AAAA, 1'b0);
        // Back-to-back file starts, then a restart in the middle of a block.
        send_word(rand_word(), 1'b1);
        send_word(rand_word(), 1'b1);
        send_word(rand_word(), 1'b1);
        send_word(rand_word(), 1'b0);
        send_word(rand_word(), 1'b0);
        send_word(rand_word(), 1'b1);
        send_word(rand_word(), 1'b0);
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 10; recv_idle_pct = 46; end
                1: begin send_idle_pct = 46; recv_idle_pct = 10; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            phase_sent = 0;
            if (phase == 0)
                hold_reqs <= hold_reqs + 1;
            while (phase_sent < PHASE_WORDS) begin
                case ($urandom_range(7))
                    0:       len = BLOCK_WORDS;
                    1, 2:    len = $urandom_range(BLOCK_WORDS + 1, 2 * BLOCK_WORDS + 40);
                    default: len = $urandom_range(1, 40);
                endcase
                // Keep each phase close to its word budget.
                if (len > PHASE_WORDS - phase_sent)
                    len = PHASE_WORDS - phase_sent;
                send_file(len);
                // Now and then a stray burst with start flags at random.
                if ($urandom_range(4) == 0) begin
                    repeat ($urandom_range(1, 6))
                        send_word(rand_word(), $urandom_range(7) == 0);
                end
            end
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/rxwd_pkg.sv
rtl/rxwd_blkinit.sv
rtl/rxwd_core.sv
rtl/rolling_xor_word_decryptor.sv
test/rxwd_checker.sv
test/tb.sv
